### design/itaf_pkg.sv
// Shared types and character constants of the integer to ASCII formatter.
package itaf_pkg;

	// Format modes carried in the action field
	localparam logic [1:0] ACT_SIGNED_DEC   = 2'd0;
	localparam logic [1:0] ACT_UNSIGNED_DEC = 2'd1;
	localparam logic [1:0] ACT_HEX          = 2'd2;

	// Character codes
	localparam logic [7:0] ASCII_ZERO  = 8'h30;
	localparam logic [7:0] ASCII_MINUS = 8'h2D;
	localparam logic [7:0] ASCII_UPPER_A = 8'h41;

	// Number base and digit geometry
	localparam int unsigned DEC_BASE   = 10;
	localparam int unsigned HEX_BASE   = 16;
	localparam int unsigned WORD_W     = 32;
	localparam int unsigned NUM_DIGITS = 10;
	localparam int unsigned DIGIT_W    = 4;
	localparam int unsigned DIGITS_W   = NUM_DIGITS * DIGIT_W;
	localparam int unsigned IDX_W      = 4;
	localparam int unsigned CNT_W      = 5;

	typedef struct packed {
		logic [1:0]        action;
		logic [WORD_W-1:0] value;
	} in_t;

	typedef struct packed {
		logic [7:0] ascii_char;
		logic       last;
	} out_t;

	// Commands from the controller to the datapath
	typedef struct packed {
		logic load;
		logic dabble;
		logic step_down;
		logic sel_sign;
	} cmd_t;

	// Status from the datapath to the controller
	typedef struct packed {
		logic neg;
		logic skip;
		logic idx_zero;
	} sts_t;

endpackage

### design/itaf_dpath.sv
// Datapath: operand registers, shift-add-3 converter, digit selection and character coding.
module itaf_dpath (
	input  logic          clk,
	input  itaf_pkg::in_t in_data,
	input  itaf_pkg::cmd_t cmd,
	output itaf_pkg::sts_t sts,
	output itaf_pkg::out_t out_data
);

	logic [itaf_pkg::WORD_W-1:0]   bin_q;
	logic [itaf_pkg::DIGITS_W-1:0] dig_q;
	logic [itaf_pkg::IDX_W-1:0]    idx_q;
	logic                          neg_q;

	logic                          is_neg;
	logic [itaf_pkg::WORD_W-1:0]   mag;
	logic [itaf_pkg::DIGITS_W-1:0] dig_adj;
	logic [itaf_pkg::DIGIT_W-1:0]  cur_nib;
	logic [7:0]                    digit_char;

	// Magnitude of the incoming word; only signed mode with the top bit set is negative.
	always_comb begin
		is_neg = (in_data.action == itaf_pkg::ACT_SIGNED_DEC) && in_data.value[itaf_pkg::WORD_W-1];
		mag    = is_neg ? (~in_data.value + 32'd1) : in_data.value;
	end

	// Add three to every BCD digit of five or more before the next shift.
	always_comb begin
		for (int i = 0; i < itaf_pkg::NUM_DIGITS; i++) begin
			if (dig_q[i*itaf_pkg::DIGIT_W +: itaf_pkg::DIGIT_W] >= 4'd5) begin
				dig_adj[i*itaf_pkg::DIGIT_W +: itaf_pkg::DIGIT_W] =
					dig_q[i*itaf_pkg::DIGIT_W +: itaf_pkg::DIGIT_W] + 4'd3;
			end else begin
				dig_adj[i*itaf_pkg::DIGIT_W +: itaf_pkg::DIGIT_W] =
					dig_q[i*itaf_pkg::DIGIT_W +: itaf_pkg::DIGIT_W];
			end
		end
	end

	// Operand and digit registers.
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			neg_q <= is_neg;
			idx_q <= 4'(itaf_pkg::NUM_DIGITS - 1);
			if (in_data.action[1]) begin
				// Hexadecimal needs no conversion: the nibbles are the digits.
				dig_q <= {{(itaf_pkg::DIGITS_W - itaf_pkg::WORD_W){1'b0}}, in_data.value};
				bin_q <= '0;
			end else begin
				dig_q <= '0;
				bin_q <= mag;
			end
		end else if (cmd.dabble) begin
			{dig_q, bin_q} <= {dig_adj[itaf_pkg::DIGITS_W-2:0], bin_q, 1'b0};
		end else if (cmd.step_down) begin
			idx_q <= idx_q - 4'd1;
		end
	end

	// Digit under the index and its character.
	always_comb begin
		cur_nib = dig_q[{idx_q, 2'b00} +: itaf_pkg::DIGIT_W];
		if (cur_nib < 4'(itaf_pkg::DEC_BASE)) begin
			digit_char = itaf_pkg::ASCII_ZERO + {4'd0, cur_nib};
		end else begin
			digit_char = itaf_pkg::ASCII_UPPER_A + {4'd0, cur_nib} - 8'(itaf_pkg::DEC_BASE);
		end
	end

	// Status and output character.
	always_comb begin
		sts.neg      = neg_q;
		sts.idx_zero = (idx_q == '0);
		sts.skip     = (idx_q != '0) && (cur_nib == '0);
		if (cmd.sel_sign) begin
			out_data.ascii_char = itaf_pkg::ASCII_MINUS;
			out_data.last       = 1'b0;
		end else begin
			out_data.ascii_char = digit_char;
			out_data.last       = (idx_q == '0);
		end
	end

endmodule

### design/itaf_ctrl.sv
// Controller: sequences loading, conversion, leading zero skip and character output.
module itaf_ctrl (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           in_valid,
	input  logic           in_hex,
	output logic           in_ready,
	output logic           out_valid,
	input  logic           out_ready,
	input  itaf_pkg::sts_t sts,
	output itaf_pkg::cmd_t cmd
);

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_CONV,
		ST_SCAN,
		ST_SIGN,
		ST_DIGIT
	} state_t;

	state_t                     state_q;
	logic [itaf_pkg::CNT_W-1:0] cnt_q;

	// Commands decoded from the current state and handshakes.
	always_comb begin
		cmd       = '0;
		in_ready  = 1'b0;
		out_valid = 1'b0;
		case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				cmd.load = in_valid;
			end
			ST_CONV: begin
				cmd.dabble = 1'b1;
			end
			ST_SCAN: begin
				cmd.step_down = sts.skip;
			end
			ST_SIGN: begin
				out_valid    = 1'b1;
				cmd.sel_sign = 1'b1;
			end
			ST_DIGIT: begin
				out_valid     = 1'b1;
				cmd.step_down = out_ready && !sts.idx_zero;
			end
			default: begin
				cmd = '0;
			end
		endcase
	end

	// State register and conversion step counter.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			cnt_q   <= '0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					cnt_q <= '0;
					if (in_valid) begin
						state_q <= in_hex ? ST_SCAN : ST_CONV;
					end
				end
				ST_CONV: begin
					cnt_q <= cnt_q + 5'd1;
					if (cnt_q == 5'(itaf_pkg::WORD_W - 1)) begin
						state_q <= ST_SCAN;
					end
				end
				ST_SCAN: begin
					if (!sts.skip) begin
						state_q <= sts.neg ? ST_SIGN : ST_DIGIT;
					end
				end
				ST_SIGN: begin
					if (out_ready) begin
						state_q <= ST_DIGIT;
					end
				end
				ST_DIGIT: begin
					if (out_ready && sts.idx_zero) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

endmodule

### design/integer_to_ascii_formatter_core.sv
// Top level of the integer to ASCII formatter: controller and datapath.
//
//  Channel | Direction | Handshake            | Payload
//  in      | input     | in_valid / in_ready  | in_data  (action, value)
//  out     | output    | out_valid / out_ready| out_data (ascii_char, last)
//
// One number is handled at a time. A decimal number is loaded, converted by
// the shift-add-3 converter, then leading zeros are skipped to find the first
// digit, and the characters are given out one after another; hexadecimal
// skips the converter.
// A stalled output holds the state and the character until it is taken.
// Reset returns the controller to idle; the datapath registers need none.
module integer_to_ascii_formatter_core (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           in_valid,
	output logic           in_ready,
	input  itaf_pkg::in_t  in_data,
	output logic           out_valid,
	input  logic           out_ready,
	output itaf_pkg::out_t out_data
);

	itaf_pkg::cmd_t cmd;
	itaf_pkg::sts_t sts;

	// Sequencing of one transaction.
	itaf_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_hex    (in_data.action[1]),
		.in_ready  (in_ready),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.sts       (sts),
		.cmd       (cmd)
	);

	// Conversion and character generation.
	itaf_dpath u_dpath (
		.clk      (clk),
		.in_data  (in_data),
		.cmd      (cmd),
		.sts      (sts),
		.out_data (out_data)
	);

endmodule

### sim/tb_top.sv
// Self-checking testbench of the integer to ASCII formatter core.
`timescale 1ns / 1ps

module tb_top;

	// Mode 3 is not named in the package; the block treats it as hexadecimal.
	localparam logic [1:0] ACT_SPARE = 2'd3;

	localparam int DIR_ROWS     = 21;
	localparam int PHASES       = 7;
	localparam int PHASE_ITEMS  = 60;
	localparam int HOLD_CYCLES  = 300;
	localparam int TAIL_CYCLES  = 60;
	localparam int CYCLE_LIMIT  = 600000;
	localparam int SHOWN_ERRORS = 10;

	logic           clk = 1'b0;
	logic           arst_n = 1'b0;
	logic           in_valid = 1'b0;
	logic           in_ready;
	itaf_pkg::in_t  in_data = '0;
	logic           out_valid;
	logic           out_ready = 1'b0;
	itaf_pkg::out_t out_data;

	// Characters still to come from the block, oldest first.
	itaf_pkg::out_t expected_chars[$];
	int   mismatch_count = 0;
	int   cycle_count = 0;
	bit   sender_quiet = 1'b0;
	bit   receiver_quiet = 1'b0;
	bit   hold_request = 1'b0;

	// Directed rows: an empty text means the row is checked against the predictor.
	itaf_pkg::in_t dir_item [DIR_ROWS] = '{
		'{itaf_pkg::ACT_SIGNED_DEC,   32'h0000_0000},
		'{itaf_pkg::ACT_UNSIGNED_DEC, 32'h0000_0000},
		'{itaf_pkg::ACT_HEX,          32'h0000_0000},
		'{ACT_SPARE,                  32'h0000_0000},
		'{itaf_pkg::ACT_SIGNED_DEC,   32'h8000_0000},
		'{itaf_pkg::ACT_SIGNED_DEC,   32'h7FFF_FFFF},
		'{itaf_pkg::ACT_SIGNED_DEC,   32'hFFFF_FFFF},
		'{itaf_pkg::ACT_UNSIGNED_DEC, 32'hFFFF_FFFF},
		'{itaf_pkg::ACT_UNSIGNED_DEC, 32'h8000_0000},
		'{itaf_pkg::ACT_HEX,          32'hFFFF_FFFF},
		'{itaf_pkg::ACT_HEX,          32'h8000_0000},
		'{ACT_SPARE,                  32'hDEAD_BEEF},
		'{itaf_pkg::ACT_SIGNED_DEC,   32'd1},
		'{itaf_pkg::ACT_SIGNED_DEC,   32'd9},
		'{itaf_pkg::ACT_UNSIGNED_DEC, 32'd10},
		'{itaf_pkg::ACT_UNSIGNED_DEC, 32'd1000000000},
		'{itaf_pkg::ACT_HEX,          32'h0000_000A},
		'{itaf_pkg::ACT_SIGNED_DEC,   32'h1234_5678},
		'{itaf_pkg::ACT_UNSIGNED_DEC, 32'h0BAD_F00D},
		'{itaf_pkg::ACT_HEX,          32'h00AB_CDEF},
		'{itaf_pkg::ACT_SIGNED_DEC,   32'hC000_0001}
	};
	string dir_text [DIR_ROWS] = '{
		"0", "0", "0", "0", "-2147483648", "2147483647", "-1", "4294967295",
		"2147483648", "FFFFFFFF", "80000000", "DEADBEEF", "1", "9", "10",
		"1000000000", "A", "", "", "", ""
	};

	integer_to_ascii_formatter_core dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data)
	);

	initial begin
		forever #10 clk = ~clk;
	end

	// Queue a typed-in string as the characters expected for one number.
	function automatic void queue_text(string text);
		itaf_pkg::out_t ch;
		for (int i = 0; i < text.len(); i++) begin
			ch.ascii_char = text[i];
			ch.last       = (i == text.len() - 1);
			expected_chars.push_back(ch);
		end
	endfunction

	// Work out the characters of one number, most significant first.
	function automatic void queue_formatted(itaf_pkg::in_t item);
		logic [7:0]     digits[$];
		logic [31:0]    mag;
		logic [3:0]     nib;
		itaf_pkg::out_t ch;
		mag = item.value;
		if (item.action[1]) begin
			do begin
				nib = mag[3:0];
				digits.push_front(nib < 4'd10 ? itaf_pkg::ASCII_ZERO + 8'(nib)
				                              : itaf_pkg::ASCII_UPPER_A + 8'(nib - 4'd10));
				mag = mag >> 4;
			end while (mag != 0);
		end else begin
			if (item.action == itaf_pkg::ACT_SIGNED_DEC && item.value[31])
				mag = 32'd0 - item.value;
			do begin
				digits.push_front(itaf_pkg::ASCII_ZERO + 8'(mag % itaf_pkg::DEC_BASE));
				mag = mag / itaf_pkg::DEC_BASE;
			end while (mag != 0);
			if (item.action == itaf_pkg::ACT_SIGNED_DEC && item.value[31])
				digits.push_front(itaf_pkg::ASCII_MINUS);
		end
		for (int i = 0; i < digits.size(); i++) begin
			ch.ascii_char = digits[i];
			ch.last       = (i == digits.size() - 1);
			expected_chars.push_back(ch);
		end
	endfunction

	// Random word: mostly of random bit length, sometimes near a power of ten.
	function automatic logic [31:0] random_word();
		logic [32:0] mask;
		logic [31:0] word;
		int          bits;
		if ($urandom_range(0, 5) == 0) begin
			word = 32'd1;
			repeat ($urandom_range(0, 9)) word = word * 32'd10;
			word = word - 32'($urandom_range(0, 1));
			if ($urandom_range(0, 3) == 0)
				word = ~word;
		end else begin
			bits = $urandom_range(0, 32);
			mask = (33'd1 << bits) - 33'd1;
			word = $urandom & mask[31:0];
		end
		return word;
	endfunction

	function automatic logic [1:0] random_action();
		if ($urandom_range(0, 7) == 0)
			return ACT_SPARE;
		return 2'($urandom_range(0, 2));
	endfunction

	// Offer one transaction after a random gap and hold it until it is taken.
	task automatic send_number(itaf_pkg::in_t item, string text);
		int gap;
		gap = sender_quiet ? 0 : $urandom_range(0, 10);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		in_data  <= item;
		do @(posedge clk); while (!in_ready);
		if (text.len() > 0)
			queue_text(text);
		else
			queue_formatted(item);
	endtask

	// Withdraw the input and wait until every expected character has come.
	task automatic wait_drained();
		in_valid <= 1'b0;
		while (expected_chars.size() != 0) @(posedge clk);
	endtask

	// Compare one accepted character with the oldest expectation.
	task automatic check_char(itaf_pkg::out_t got);
		itaf_pkg::out_t want;
		if (expected_chars.size() == 0) begin
			mismatch_count++;
			if (mismatch_count <= SHOWN_ERRORS)
				$display("Unexpected character %h last %b", got.ascii_char, got.last);
		end else begin
			want = expected_chars.pop_front();
			if (got.ascii_char !== want.ascii_char || got.last !== want.last) begin
				mismatch_count++;
				if (mismatch_count <= SHOWN_ERRORS)
					$display("Mismatch: expected char %h last %b, got char %h last %b",
					         want.ascii_char, want.last, got.ascii_char, got.last);
			end
		end
	endtask

	// Receiver: random stalls, one long hold-off on request.
	initial begin
		int stall;
		wait (arst_n === 1'b1);
		forever begin
			if (hold_request) begin
				hold_request = 1'b0;
				out_ready <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
			end else begin
				stall = receiver_quiet ? 0 : $urandom_range(0, 10);
				if (stall > 0) begin
					out_ready <= 1'b0;
					repeat (stall) @(posedge clk);
				end
			end
			out_ready <= 1'b1;
			do @(posedge clk); while (!out_valid);
			check_char(out_data);
		end
	end

	// Run limit.
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("Regression FAIL");
			$finish;
		end
	end

	// Main sequence: reset, directed table, then phases of random numbers.
	initial begin
		itaf_pkg::in_t item;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);

		for (int row = 0; row < DIR_ROWS; row++)
			send_number(dir_item[row], dir_text[row]);
		wait_drained();

		for (int phase = 0; phase < PHASES; phase++) begin
			sender_quiet   = (phase == 2);
			receiver_quiet = (phase == 2);
			if (phase == 4)
				hold_request = 1'b1;
			for (int n = 0; n < PHASE_ITEMS; n++) begin
				item.action = random_action();
				item.value  = random_word();
				send_number(item, "");
			end
			// On odd phases, hold the input back until every character of the phase is out.
			if (phase % 2 == 1)
				wait_drained();
		end

		wait_drained();
		repeat (TAIL_CYCLES) @(posedge clk);
		if (mismatch_count == 0 && expected_chars.size() == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end

endmodule

### sim.f
design/itaf_pkg.sv
design/itaf_dpath.sv
design/itaf_ctrl.sv
design/integer_to_ascii_formatter_core.sv
sim/tb_top.sv
